/* rtl/rsw_pkg.sv */
`timescale 1ns / 1ps
// rsw_pkg: shared types and constants for the resampling wheel
// no dependencies; imported by rsw_alu and resampling_wheel

package rsw_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int WEIGHT_BITS_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SWEEPS     = 3;
    localparam int KIND_W     = 2;
    localparam int WEIGHT_W   = 32;
    localparam int SLOT_W     = 6;
    localparam int FRAC_W     = 16;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int SLOT_COUNT = 2 ** SLOT_W;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd10;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

/* rtl/resampling_wheel.sv */
`timescale 1ns / 1ps
// resampling_wheel: particle filter resampling wheel, one draw at a time
// depends on rsw_pkg and rsw_alu (shared add/subtract unit)
//
//  channel  dir  fields
//  s_*      in   tuser: kind; tdata: weight, slot, start_index, random_fraction
//  m_*      out  tuser: kept_unchanged; tdata: chosen_index
//  cfg_*    in   particle_count, written when cfg_we is high
//
// load, start and unknown words are handled in the idle state alone; a draw with all weights zero
// goes straight to the emit state. any other draw runs the multiply, add, walk and emit states in order: the
// shared adder runs a shift-add multiply one fraction bit a cycle, then the wheel walk reads the
// weight store one entry a cycle, at most 3 x particle_count steps.
// reset is asynchronous; the weight store is not cleared and needs loads first.
// a finished result waits in the output register; a draw holds its last cycle until it is free.

module resampling_wheel #(
    parameter int MAX_PARTICLES = rsw_pkg::MAX_PARTICLES_DEF,
    parameter int WEIGHT_BITS   = rsw_pkg::WEIGHT_BITS_DEF,
    parameter int FRACTION_BITS = rsw_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // weight[31:0], slot[37:32], start_index[43:38], random_fraction[59:44]
    input  logic [rsw_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [rsw_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // chosen_index[5:0]
    output logic [rsw_pkg::M_TDATA_W-1:0]  m_tdata,
    // kept_unchanged[0]
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [rsw_pkg::COUNT_W-1:0]    cfg_wdata
);
    import rsw_pkg::*;

    localparam int IW    = $clog2(MAX_PARTICLES);
    localparam int NW    = $clog2(MAX_PARTICLES + 1);
    localparam int SW    = $clog2(SWEEPS * MAX_PARTICLES + 1);
    localparam int AW    = WEIGHT_BITS + FRACTION_BITS;
    localparam int ACW   = WEIGHT_BITS + 2;
    localparam int FCW   = $clog2(FRACTION_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    function automatic logic [SLOT_COUNT*IW-1:0] build_slot_map();
        logic [SLOT_COUNT*IW-1:0] m;
        m = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            m[i*IW +: IW] = IW'(i % MAX_PARTICLES);
        end
        return m;
    endfunction

    localparam logic [SLOT_COUNT*IW-1:0] SLOT_MAP = build_slot_map();

    function automatic logic [IW-1:0] adv(input logic [IW-1:0] i, input logic [NW-1:0] nn);
        logic [NW:0] inc;
        inc = (NW+1)'(i) + 1'b1;
        return (inc >= (NW+1)'(nn)) ? '0 : IW'(inc);
    endfunction

    // input fields
    logic [KIND_W-1:0]        in_kind;
    logic [WEIGHT_BITS-1:0]   in_weight;
    logic [SLOT_W-1:0]        in_slot;
    logic [INDEX_W-1:0]       in_start;
    logic [FRACTION_BITS-1:0] in_frac;
    logic [IW-1:0]            slot_idx;

    assign in_kind   = s_tuser;
    assign in_weight = WEIGHT_BITS'(s_tdata[31:0]);
    assign in_slot   = s_tdata[37:32];
    assign in_start  = s_tdata[43:38];
    assign in_frac   = FRACTION_BITS'(s_tdata[59:44]);
    assign slot_idx  = SLOT_MAP[in_slot*IW +: IW];

    // control state
    logic [2:0]             state_reg,   state_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [WEIGHT_BITS-1:0] largest_reg, largest_next;
    logic [ACW-1:0]         acc_reg,     acc_next;
    logic [IW-1:0]          pos_reg,     pos_next;
    logic [IW-1:0]          dpos_reg,    dpos_next;
    logic                   mvalid_reg,  mvalid_next;

    // datapath
    logic [AW-1:0]            prod_reg,  prod_next;
    logic [FRACTION_BITS-1:0] frac_reg,  frac_next;
    logic [FCW-1:0]           mcnt_reg,  mcnt_next;
    logic [SW-1:0]            steps_reg, steps_next;
    logic [SW-1:0]            limit_reg, limit_next;
    logic [INDEX_W-1:0]       res_idx_reg, res_idx_next;
    logic                     res_kept_reg, res_kept_next;
    logic [INDEX_W-1:0]       out_idx_reg, out_idx_next;
    logic                     out_kept_reg, out_kept_next;
    logic [WEIGHT_BITS-1:0]   rd_reg;

    logic [WEIGHT_BITS-1:0] store_mem [MAX_PARTICLES];

    logic [NW-1:0]   n_eff;
    logic            s_fire;
    logic            load_we;
    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   pos_adv;
    logic [AW-1:0]   alu_a, alu_b;
    alu_op_t         alu_op;
    logic [AW:0]     alu_y;
    logic            walk_stop;

    rsw_alu #(.W(AW)) u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    always_comb
    begin
        if (count_reg == '0)
            n_eff = NW'(1);
        else if (int'(count_reg) > MAX_PARTICLES)
            n_eff = NW'(MAX_PARTICLES);
        else
            n_eff = NW'(count_reg);
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign load_we  = s_fire && (in_kind == KIND_LOAD);
    assign pos_adv  = adv(pos_reg, n_eff);
    assign rd_addr  = (state_reg == S_WALK) ? pos_adv : pos_reg;

    // shared unit operand select
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_MUL:
            begin
                alu_a = {prod_reg[AW-2:0], 1'b0};
                alu_b = frac_reg[FRACTION_BITS-1] ? AW'(largest_reg) : '0;
            end
            S_ADD:
            begin
                alu_a = AW'(acc_reg);
                alu_b = prod_reg >> (FRACTION_BITS - 1);
            end
            S_WALK:
            begin
                alu_op = ALU_SUB;
                alu_a  = AW'(acc_reg);
                alu_b  = AW'(rd_reg);
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // stop when the sweep limit is reached or the accumulator fits
    assign walk_stop = (steps_reg == limit_reg) || alu_y[AW] || (alu_y[AW-1:0] == '0);

    always_comb
    begin
        state_next    = state_reg;
        largest_next  = largest_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        dpos_next     = dpos_reg;
        mvalid_next   = mvalid_reg;
        prod_next     = prod_reg;
        frac_next     = frac_reg;
        mcnt_next     = mcnt_reg;
        steps_next    = steps_reg;
        limit_next    = limit_reg;
        res_idx_next  = res_idx_reg;
        res_kept_next = res_kept_reg;
        out_idx_next  = out_idx_reg;
        out_kept_next = out_kept_reg;

        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (in_kind)
                        KIND_LOAD:
                        begin
                            if (slot_idx == '0 || in_weight > largest_reg)
                                largest_next = in_weight;
                        end
                        KIND_START:
                        begin
                            pos_next  = ((NW+INDEX_W)'(in_start) < (NW+INDEX_W)'(n_eff))
                                        ? IW'(in_start) : '0;
                            acc_next  = '0;
                            dpos_next = '0;
                        end
                        KIND_DRAW:
                        begin
                            dpos_next  = adv(dpos_reg, n_eff);
                            limit_next = SW'(n_eff) * SW'(SWEEPS);
                            if (largest_reg == '0)
                            begin
                                res_idx_next  = INDEX_W'(dpos_reg);
                                res_kept_next = 1'b1;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                prod_next  = '0;
                                frac_next  = in_frac;
                                mcnt_next  = FCW'(FRACTION_BITS - 1);
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next = alu_y[AW-1:0];
                frac_next = {frac_reg[FRACTION_BITS-2:0], 1'b0};
                mcnt_next = mcnt_reg - 1'b1;
                if (mcnt_reg == '0)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                // saturate the accumulator at all ones
                if (alu_y[AW:ACW] != '0)
                    acc_next = '1;
                else
                    acc_next = alu_y[ACW-1:0];
                steps_next = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (walk_stop)
                begin
                    res_idx_next  = INDEX_W'(pos_reg);
                    res_kept_next = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    acc_next   = alu_y[ACW-1:0];
                    pos_next   = pos_adv;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    out_idx_next  = res_idx_reg;
                    out_kept_next = res_kept_reg;
                    mvalid_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= COUNT_RESET;
            largest_reg <= '0;
            acc_reg     <= '0;
            pos_reg     <= '0;
            dpos_reg    <= '0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            largest_reg <= largest_next;
            acc_reg     <= acc_next;
            pos_reg     <= pos_next;
            dpos_reg    <= dpos_next;
            mvalid_reg  <= mvalid_next;
            if (cfg_we)
                count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        frac_reg     <= frac_next;
        mcnt_reg     <= mcnt_next;
        steps_reg    <= steps_next;
        limit_reg    <= limit_next;
        res_idx_reg  <= res_idx_next;
        res_kept_reg <= res_kept_next;
        out_idx_reg  <= out_idx_next;
        out_kept_reg <= out_kept_next;
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (load_we)
            store_mem[slot_idx] <= in_weight;
        rd_reg <= store_mem[rd_addr];
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_idx_reg);
    assign m_tuser  = out_kept_reg;

endmodule

/* rtl/rsw_alu.sv */
`timescale 1ns / 1ps
// rsw_alu: shared adder / subtractor with carry-borrow out
// depends on rsw_pkg for the operation codes

module rsw_alu #(
    parameter int W = 48
) (
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    input  rsw_pkg::alu_op_t  op,
    output logic [W:0]        y
);
    import rsw_pkg::*;

    always_comb
    begin
        unique case (op)
            ALU_ADD: y = {1'b0, a} + {1'b0, b};
            ALU_SUB: y = {1'b0, a} - {1'b0, b};
            default: y = {1'b0, a} + {1'b0, b};
        endcase
    end

endmodule
